/* rtl/heading_to_differential_drive_defines.svh */
`ifndef HEADING_TO_DIFFERENTIAL_DRIVE_DEFINES_SVH
`define HEADING_TO_DIFFERENTIAL_DRIVE_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off while in reset
`define HTDD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// Next-cycle implication, clocked on i_clk, off while in reset
`define HTDD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

/* rtl/htdd_pkg.sv */
package htdd_pkg;

    localparam logic CFG_ENABLE = 1'b0;
    localparam logic CFG_SPEED  = 1'b1;

    localparam logic [2:0] CLS_FORWARD = 3'd0;
    localparam logic [2:0] CLS_RIGHT   = 3'd1;
    localparam logic [2:0] CLS_BACK    = 3'd2;
    localparam logic [2:0] CLS_LEFT    = 3'd3;
    localparam logic [2:0] CLS_NONE    = 3'd4;

    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_BWD  = 2'd2;

    localparam logic [7:0] DUTY_MIN     = 8'd50;
    localparam logic [7:0] DUTY_DEFAULT = 8'd150;

    // n / 270 as (n * RECIP_270) >> 24, exact for n < 2^16
    localparam logic [15:0] RECIP_270   = 16'd62138;
    localparam int          SHIFT_270   = 24;
    localparam logic [15:0] HALF_270    = 16'd135;
    // n / 12150 as (n * RECIP_12150) >> 36, exact for n < 2^22
    localparam logic [22:0] RECIP_12150 = 23'd5655925;
    localparam int          SHIFT_12150 = 36;
    localparam logic [21:0] HALF_12150  = 22'd6075;

    typedef struct packed {
        logic       stop;
        logic [2:0] cls;
        logic [1:0] ld;
        logic [1:0] rd;
        logic       sel_l;
        logic       sel_r;
    } t_tag;

endpackage

/* rtl/heading_to_differential_drive.sv */
// Heading to differential-drive converter.
// Command channel: a beat is taken on a rising edge with start high and busy
// low. busy is always low, so a command can be issued every cycle.
// Payload i_action (0 set heading, 1 stop) and i_heading (degrees, any 12-bit
// value, reduced modulo 360).
// Configuration channel: i_cfg_valid/o_cfg_ready with i_cfg_index
// (0 enable, 1 speed_duty) and i_cfg_data; o_cfg_ready is always high.
// Write it only while no command is in flight.
// Result: o_done is high for one cycle with class, wheel directions and duties.
// Throughput is one command per cycle. A seven-register pipeline runs from the
// accepting edge to o_done: modulo reduction over two stages, class and factor
// decode, three multiplier stages (base times slow-down, direction scaling
// with the first reciprocal divide, the second reciprocal divide), then the
// output register.
// While enable is 0 commands are taken and dropped with no result.
// Reset (synchronous, active low) clears enable, speed_duty and all valid bits.
// The receiver cannot stall; each result is shown for exactly one cycle.
`include "heading_to_differential_drive_defines.svh"

module heading_to_differential_drive (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_action,
    input  logic [11:0] i_heading,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output logic        o_done,
    output logic [2:0]  o_heading_class,
    output logic [1:0]  o_left_dir,
    output logic [1:0]  o_right_dir,
    output logic [7:0]  o_left_duty,
    output logic [7:0]  o_right_duty
);
    import htdd_pkg::*;

    logic       r_enable;
    logic [7:0] r_speed_duty;
    logic [7:1] r_v;

    logic        r_stop1, r_stop2;
    logic [10:0] r_x1;
    logic [8:0]  r_h2;
    t_tag        r_tag3, r_tag4, r_tag5, r_tag6;
    logic [7:0]  r_a3;
    logic [5:0]  r_d3, r_d4;
    logic [14:0] r_ka4;
    logic [31:0] r_p5;
    logic [20:0] r_kad5;
    logic [7:0]  r_q6;
    logic [44:0] r_p6;

    logic [2:0]  r_cls7;
    logic [1:0]  r_ld7, r_rd7;
    logic [7:0]  r_lduty7, r_rduty7;

    logic        n_accept;
    logic [11:0] n_x0a;
    logic [10:0] n_x0b;
    logic [9:0]  n_x1a;
    logic [8:0]  n_h;
    logic [7:0]  n_h180;
    logic [6:0]  n_h90;
    logic [7:0]  n_a;
    logic [5:0]  n_d;
    t_tag        n_tag;
    logic [7:0]  n_base;
    logic [7:0]  n_k;
    logic [15:0] n_num1;
    logic [21:0] n_num2;
    logic [7:0]  n_q2;
    logic [7:0]  n_scaled;
    logic [7:0]  n_plain;
    logic [2:0]  n_cls;
    logic [1:0]  n_ld, n_rd;
    logic [7:0]  n_lduty, n_rduty;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign n_accept    = start && !busy && r_enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= 1'b0;
            r_speed_duty <= 8'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ENABLE: r_enable     <= i_cfg_data[0];
                CFG_SPEED:  r_speed_duty <= i_cfg_data;
                default:    r_enable     <= r_enable;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[6:1], n_accept};
        end
    end

    // stage 1 and 2: modulo 360 by conditional subtraction
    always_comb begin
        n_x0a = (i_heading >= 12'd2880) ? i_heading - 12'd2880 : i_heading;
        n_x0b = (n_x0a >= 12'd1440) ? 11'(n_x0a - 12'd1440) : n_x0a[10:0];
        n_x1a = (r_x1 >= 11'd720) ? 10'(r_x1 - 11'd720) : r_x1[9:0];
        n_h   = (n_x1a >= 10'd360) ? 9'(n_x1a - 10'd360) : n_x1a[8:0];
    end

    // stage 3: class, directions, factors
    always_comb begin
        n_h180 = (r_h2 >= 9'd180) ? 8'(r_h2 - 9'd180) : r_h2[7:0];
        n_h90  = (n_h180 >= 8'd90) ? 7'(n_h180 - 8'd90) : n_h180[6:0];
        n_a    = ((n_h180 >= 8'd90) ? n_h180 - 8'd90 : 8'd90 - n_h180) + 8'd45;
        n_d    = 6'((n_h90 >= 7'd45) ? n_h90 - 7'd45 : 7'd45 - n_h90);

        priority if (r_h2 >= 9'd315 || r_h2 <= 9'd45) begin
            n_tag.cls = CLS_FORWARD;
        end else if (r_h2 < 9'd135) begin
            n_tag.cls = CLS_RIGHT;
        end else if (r_h2 <= 9'd225) begin
            n_tag.cls = CLS_BACK;
        end else begin
            n_tag.cls = CLS_LEFT;
        end

        priority if (r_h2 == 9'd225 || r_h2 == 9'd315) begin
            n_tag.ld = DIR_STOP;
        end else if ((r_h2 > 9'd90 && r_h2 < 9'd225) || (r_h2 >= 9'd270 && r_h2 < 9'd315)) begin
            n_tag.ld = DIR_BWD;
        end else begin
            n_tag.ld = DIR_FWD;
        end

        priority if (r_h2 == 9'd45 || r_h2 == 9'd135) begin
            n_tag.rd = DIR_STOP;
        end else if ((r_h2 > 9'd45 && r_h2 <= 9'd90) || (r_h2 > 9'd135 && r_h2 < 9'd270)) begin
            n_tag.rd = DIR_BWD;
        end else begin
            n_tag.rd = DIR_FWD;
        end

        n_tag.stop  = r_stop2;
        n_tag.sel_l = (r_h2 > 9'd180);
        n_tag.sel_r = (r_h2 != 9'd0) && (r_h2 < 9'd180);
    end

    // stage 4 onward: duty arithmetic
    always_comb begin
        priority if (r_speed_duty == 8'd0) begin
            n_base = DUTY_DEFAULT;
        end else if (r_speed_duty < DUTY_MIN) begin
            n_base = DUTY_MIN;
        end else begin
            n_base = r_speed_duty;
        end
        n_k    = n_base - DUTY_MIN;
        n_num1 = {r_ka4, 1'b0} + HALF_270;
        n_num2 = {r_kad5, 1'b0} + HALF_12150;
    end

    always_comb begin
        n_q2     = r_p6[SHIFT_12150 +: 8];
        n_scaled = DUTY_MIN + n_q2;
        n_plain  = DUTY_MIN + r_q6;
        if (r_tag6.stop) begin
            n_cls   = CLS_NONE;
            n_ld    = DIR_STOP;
            n_rd    = DIR_STOP;
            n_lduty = 8'd0;
            n_rduty = 8'd0;
        end else begin
            n_cls   = r_tag6.cls;
            n_ld    = r_tag6.ld;
            n_rd    = r_tag6.rd;
            n_lduty = r_tag6.sel_l ? n_scaled : n_plain;
            n_rduty = r_tag6.sel_r ? n_scaled : n_plain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stop1  <= i_action;
        r_x1     <= n_x0b;
        r_stop2  <= r_stop1;
        r_h2     <= n_h;
        r_tag3   <= n_tag;
        r_a3     <= n_a;
        r_d3     <= n_d;
        r_tag4   <= r_tag3;
        r_ka4    <= 15'(n_k * r_a3);
        r_d4     <= r_d3;
        r_tag5   <= r_tag4;
        r_p5     <= n_num1 * RECIP_270;
        r_kad5   <= 21'(r_ka4 * r_d4);
        r_tag6   <= r_tag5;
        r_q6     <= r_p5[SHIFT_270 +: 8];
        r_p6     <= n_num2 * RECIP_12150;
        r_cls7   <= n_cls;
        r_ld7    <= n_ld;
        r_rd7    <= n_rd;
        r_lduty7 <= n_lduty;
        r_rduty7 <= n_rduty;
    end

    assign o_done          = r_v[7];
    assign o_heading_class = r_cls7;
    assign o_left_dir      = r_ld7;
    assign o_right_dir     = r_rd7;
    assign o_left_duty     = r_lduty7;
    assign o_right_duty    = r_rduty7;

    `HTDD_ASSERT_IMPL(a_both_wheels_move, o_done && o_heading_class != CLS_NONE,
                      o_left_dir != DIR_STOP || o_right_dir != DIR_STOP)
    `HTDD_ASSERT_IMPL(a_duty_floor, o_done && o_heading_class != CLS_NONE,
                      o_left_duty >= DUTY_MIN && o_right_duty >= DUTY_MIN)
    `HTDD_ASSERT_NEXT(a_no_result_disabled, !r_enable, !o_done)

endmodule

/* sim/htdd_checker.sv */
module htdd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic        i_action,
    input  logic [11:0] i_heading,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_done,
    input  logic [2:0]  i_heading_class,
    input  logic [1:0]  i_left_dir,
    input  logic [1:0]  i_right_dir,
    input  logic [7:0]  i_left_duty,
    input  logic [7:0]  i_right_duty,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import htdd_pkg::*;

    typedef struct packed {
        logic [2:0] cls;
        logic [1:0] ld;
        logic [1:0] rd;
        logic [7:0] lduty;
        logic [7:0] rduty;
    } t_drive_cmd;

    t_drive_cmd drive_q[$];
    logic       enable_q;
    logic [7:0] speed_q;

    function automatic int abs_int(input int x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic t_drive_cmd predict_drive(input logic act, input logic [11:0] hd,
                                                 input logic [7:0] speed);
        t_drive_cmd cmd;
        int h;
        int base;
        int k;
        int a;
        int d;
        int lnum;
        int rnum;
        h = int'(hd) % 360;
        if (act) begin
            cmd.cls   = CLS_NONE;
            cmd.ld    = DIR_STOP;
            cmd.rd    = DIR_STOP;
            cmd.lduty = 8'd0;
            cmd.rduty = 8'd0;
            return cmd;
        end
        base = int'(speed);
        if (base == 0) begin
            base = int'(DUTY_DEFAULT);
        end else if (base < int'(DUTY_MIN)) begin
            base = int'(DUTY_MIN);
        end
        k = base - int'(DUTY_MIN);

        if (h >= 315 || h <= 45) begin
            cmd.cls = CLS_FORWARD;
        end else if (h < 135) begin
            cmd.cls = CLS_RIGHT;
        end else if (h <= 225) begin
            cmd.cls = CLS_BACK;
        end else begin
            cmd.cls = CLS_LEFT;
        end

        if (h == 225 || h == 315) begin
            cmd.ld = DIR_STOP;
        end else if ((h > 90 && h < 225) || (h >= 270 && h < 315)) begin
            cmd.ld = DIR_BWD;
        end else begin
            cmd.ld = DIR_FWD;
        end

        if (h == 45 || h == 135) begin
            cmd.rd = DIR_STOP;
        end else if ((h > 45 && h <= 90) || (h > 135 && h < 270)) begin
            cmd.rd = DIR_BWD;
        end else begin
            cmd.rd = DIR_FWD;
        end

        a = abs_int(h % 180 - 90) + 45;
        d = abs_int(h % 90 - 45);
        lnum = int'(DUTY_MIN) + (2 * k * a + 135) / 270;
        rnum = lnum;
        if (h > 180) begin
            lnum = int'(DUTY_MIN) + (2 * k * a * d + 6075) / 12150;
        end else if (h > 0 && h < 180) begin
            rnum = int'(DUTY_MIN) + (2 * k * a * d + 6075) / 12150;
        end
        cmd.lduty = 8'(lnum);
        cmd.rduty = 8'(rnum);
        return cmd;
    endfunction

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_drive_cmd exp_cmd;
        if (!i_rst_n) begin
            enable_q     = 1'b0;
            speed_q      = 8'd0;
            o_fail_count = 0;
            drive_q.delete();
        end else begin
            if (i_done) begin
                if (drive_q.size() == 0) begin
                    $error("heading_class: expected none, actual %0d", i_heading_class);
                    o_fail_count++;
                end else begin
                    exp_cmd = drive_q.pop_front();
                    check_field("heading_class", int'(exp_cmd.cls), int'(i_heading_class));
                    check_field("left_dir", int'(exp_cmd.ld), int'(i_left_dir));
                    check_field("right_dir", int'(exp_cmd.rd), int'(i_right_dir));
                    check_field("left_duty", int'(exp_cmd.lduty), int'(i_left_duty));
                    check_field("right_duty", int'(exp_cmd.rduty), int'(i_right_duty));
                end
            end
            if (i_start && !i_busy && enable_q) begin
                drive_q.push_back(predict_drive(i_action, i_heading, speed_q));
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_ENABLE) begin
                    enable_q = i_cfg_data[0];
                end else begin
                    speed_q = i_cfg_data;
                end
            end
        end
        o_pending = drive_q.size();
    end

endmodule

/* sim/heading_to_differential_drive_test.sv */
module heading_to_differential_drive_test;
    timeunit 1ns;
    timeprecision 1ps;
    import htdd_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int SETTLE_TICKS   = 14;
    localparam int PHASES         = 11;
    localparam int PHASE_ITEMS    = 135;
    localparam int DIRECTED_COUNT = 24;

    localparam int DIRECTED_HEADINGS[DIRECTED_COUNT] = '{
        0, 45, 46, 89, 90, 91, 134, 135, 136, 179, 180,
        181, 224, 225, 226, 269, 270, 271, 314, 315,
        316, 359, 360, 4095};
    localparam logic [7:0] SPEED_PLAN[PHASES] = '{
        8'd50, 8'd255, 8'd0, 8'd120, 8'd1, 8'd49,
        8'd51, 8'd200, 8'd100, 8'd0, 8'd0};

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_action;
    logic [11:0] i_heading;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [7:0]  i_cfg_data;
    logic        o_done;
    logic [2:0]  o_heading_class;
    logic [1:0]  o_left_dir;
    logic [1:0]  o_right_dir;
    logic [7:0]  o_left_duty;
    logic [7:0]  o_right_duty;

    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    logic gaps_on;

    heading_to_differential_drive u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_heading       (i_heading),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_done          (o_done),
        .o_heading_class (o_heading_class),
        .o_left_dir      (o_left_dir),
        .o_right_dir     (o_right_dir),
        .o_left_duty     (o_left_duty),
        .o_right_duty    (o_right_duty)
    );

    htdd_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_action        (i_action),
        .i_heading       (i_heading),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_done          (o_done),
        .i_heading_class (o_heading_class),
        .i_left_dir      (o_left_dir),
        .i_right_dir     (o_right_dir),
        .i_left_duty     (o_left_duty),
        .i_right_duty    (o_right_duty),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic issue(input logic act, input logic [11:0] hd);
        while (gaps_on && $urandom_range(99) < 17) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start     <= 1'b1;
        i_action  <= act;
        i_heading <= hd;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic random_command();
        logic        act;
        logic [11:0] hd;
        act = ($urandom_range(99) < 10);
        case ($urandom_range(3))
            0, 1: hd = 12'($urandom_range(0, 4095));
            2: hd = 12'(45 * $urandom_range(0, 8) + $urandom_range(0, 2) - 1);
            default: hd = 12'($urandom_range(0, 359) + 360 * $urandom_range(0, 10));
        endcase
        issue(act, hd);
    endtask

    // drop start, drain every expected beat, then let the pipeline empty
    task automatic settle();
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        logic [7:0] speed;

        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_action    <= 1'b0;
        i_heading   <= 12'd0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_ENABLE;
        i_cfg_data  <= 8'd0;
        gaps_on      = 1'b1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // disabled out of reset: no beats come back
        repeat (4) random_command();
        settle();
        write_reg(CFG_ENABLE, 8'h01);

        for (int n = 0; n < DIRECTED_COUNT; n++) begin
            issue(1'b0, 12'(DIRECTED_HEADINGS[n]));
        end
        issue(1'b1, 12'd4095);

        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            speed = (phase >= PHASES - 2) ? 8'($urandom_range(0, 255)) : SPEED_PLAN[phase];
            write_reg(CFG_SPEED, speed);
            if (phase == 3) begin
                write_reg(CFG_ENABLE, {7'($urandom_range(0, 127)), 1'b0});
            end else if (phase == 4) begin
                write_reg(CFG_ENABLE, {7'($urandom_range(0, 127)), 1'b1});
            end
            gaps_on = (phase != 6);
            repeat (PHASE_ITEMS) random_command();
        end
        settle();

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
